FILE: rtl/lav_pkg.sv
// ----------------------------------------------------------------------------
// lav_pkg
// Shared constants, types and arithmetic helpers of the look-at view matrix.
// ----------------------------------------------------------------------------
package lav_pkg;

  // Q16.16 coordinate format
  localparam int CW = 32;
  localparam int FB = 16;

  // unit vector component, magnitude up to 1.0
  localparam int ZW = FB + 2;
  // reoriented up component, a little headroom over a unit component
  localparam int YW = FB + 4;

  // normalizer: the largest magnitude brought to [2^(NB-1), 2^NB)
  localparam int NB = 30;
  localparam int SQ_BITS = 32;
  localparam int SQ_STG = 4;
  localparam int SQ_STEPS = SQ_BITS / SQ_STG;
  localparam int QB = FB + 1;
  localparam int DIV_STG = 3;
  localparam int DIV_STEPS = (QB + DIV_STG - 1) / DIV_STG;
  localparam int RW = NB + FB + 1;
  localparam int LW = NB + 2;

  localparam logic signed [CW-1:0] ONE_FX = CW'(64'(1) << FB);

  typedef enum logic [1:0] {
    REG_UP_X = 2'd0,
    REG_UP_Y = 2'd1,
    REG_UP_Z = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] res;
  } sq_st_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [QB-1:0] q;
  } div_st_t;

  // a slice of the digit-by-digit integer square root
  function automatic sq_st_t sqrt_steps(input sq_st_t s, input int base);
    sq_st_t r;
    logic [63:0] b;
    r = s;
    for (int j = 0; j < SQ_STEPS; j++) begin
      b = 64'(1) << (62 - 2 * (base + j));
      if (r.n >= r.res + b) begin
        r.n = r.n - (r.res + b);
        r.res = (r.res >> 1) + b;
      end else begin
        r.res = r.res >> 1;
      end
    end
    return r;
  endfunction

  // a slice of restoring division, quotient bits from the top
  function automatic div_st_t div_steps(input div_st_t s, input logic [LW-1:0] len,
                                        input int base);
    div_st_t r;
    logic [RW:0] d;
    int k;
    r = s;
    for (int j = 0; j < DIV_STEPS; j++) begin
      k = QB - 1 - (base + j);
      if (k >= 0) begin
        d = (RW + 1)'(len) << k;
        if ({1'b0, r.rem} >= d) begin
          r.rem = RW'({1'b0, r.rem} - d);
          r.q[k] = 1'b1;
        end
      end
    end
    return r;
  endfunction

  // drop FB fraction bits, round half away from zero
  function automatic logic signed [63:0] rnd_fb(input logic signed [63:0] v);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'(1) << (FB - 1))) >> FB;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = $signed((64'(1) << (CW - 1)) - 64'(1));
    lo = -hi - 64'sd1;
    if (v > hi) begin
      return CW'(hi);
    end else if (v < lo) begin
      return CW'(lo);
    end
    return CW'(v);
  endfunction

endpackage

FILE: rtl/look_at_view_matrix.sv
// ----------------------------------------------------------------------------
// look_at_view_matrix
// Left-handed look-at view matrix in Q16.16, emitted one column per word.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid_i/in_stall_o| eye xyz, target xyz
//  out     | output    | out_valid_o/out_stall_i| column index, four rows, last flag
//  cfg     | input     | cfg_valid_i/cfg_ready_o| register index, write data
//
//  one camera word in gives four column words out; the column sequencer
//  takes a new matrix only when empty or as its last column leaves
//  reset clears all valid bits and loads up = (0, 1.0, 0)
//  a stall at the output freezes every stage, bubbles included, once the
//  last stage is full; nothing is dropped or repeated
//
module look_at_view_matrix (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [lav_pkg::CW-1:0]  eye_x_i,
  input  logic signed [lav_pkg::CW-1:0]  eye_y_i,
  input  logic signed [lav_pkg::CW-1:0]  eye_z_i,
  input  logic signed [lav_pkg::CW-1:0]  target_x_i,
  input  logic signed [lav_pkg::CW-1:0]  target_y_i,
  input  logic signed [lav_pkg::CW-1:0]  target_z_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     column_index_o,
  output logic signed [lav_pkg::CW-1:0]  entry_row0_o,
  output logic signed [lav_pkg::CW-1:0]  entry_row1_o,
  output logic signed [lav_pkg::CW-1:0]  entry_row2_o,
  output logic signed [lav_pkg::CW-1:0]  entry_row3_o,
  output logic                           last_column_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [lav_pkg::CW-1:0]         cfg_data_i
);
  import lav_pkg::*;

  localparam int CPW = CW + ZW;       // exact cross(up, z)
  localparam int PCW = 2 * ZW;        // z times x products
  localparam int PEW = ZW + CW;       // unit component times eye
  localparam int DW  = YW + CW + 2;   // dot product sums
  localparam int ESW = 3 * CW;
  localparam int XSW = 3 * ZW + ESW;
  localparam logic [1:0] LAST_COL = 2'd3;
  // half an lsb of Q16.16 at the exact cross product scale
  localparam logic signed [CPW-1:0] HALF_LSB = CPW'(64'(1) << (FB - 1));

  // world up hint
  logic signed [CW-1:0] up_q [3];

  // global advance of every pipeline stage
  logic adv;
  logic ser_take;

  // input register: eye and target minus eye
  logic                 t0_v_q;
  logic signed [CW-1:0] t0_eye_q [3];
  logic signed [CW:0]   t0_d_q [3];

  // forward axis normalizer
  logic                 nz_v;
  logic signed [ZW-1:0] nz_r [3];
  logic [ESW-1:0]       nz_side;
  logic signed [CW-1:0] nz_eye [3];

  // cross(up, z) products
  logic                  t1_v_q;
  logic signed [ZW-1:0]  t1_z_q [3];
  logic signed [CW-1:0]  t1_eye_q [3];
  logic signed [CPW-1:0] t1_p_q [6];

  // exact right vector before normalizing, with the parallel-up fallback
  logic                  t2_v_q;
  logic signed [ZW-1:0]  t2_z_q [3];
  logic signed [CW-1:0]  t2_eye_q [3];
  logic signed [CPW-1:0] t2_c_q [3];
  logic signed [CPW-1:0] c_raw [3];
  logic signed [CPW-1:0] c_sel [3];
  logic                  degen;
  logic                  use_y;
  logic [ZW-1:0]         zm1;
  logic [ZW-1:0]         zm2;

  // right axis normalizer
  logic                 nx_v;
  logic signed [ZW-1:0] nx_r [3];
  logic [XSW-1:0]       nx_side;
  logic signed [ZW-1:0] nx_z [3];
  logic signed [CW-1:0] nx_eye [3];

  // cross(z, x) and the x and z dot products
  logic                  t3_v_q;
  logic signed [ZW-1:0]  t3_x_q [3];
  logic signed [ZW-1:0]  t3_z_q [3];
  logic signed [CW-1:0]  t3_eye_q [3];
  logic signed [PCW-1:0] t3_pc_q [6];
  logic signed [PEW-1:0] t3_px_q [3];
  logic signed [PEW-1:0] t3_pz_q [3];

  logic                  t4_v_q;
  logic signed [ZW-1:0]  t4_x_q [3];
  logic signed [ZW-1:0]  t4_z_q [3];
  logic signed [CW-1:0]  t4_eye_q [3];
  logic signed [YW-1:0]  t4_y_q [3];
  logic signed [DW-1:0]  t4_dx_q;
  logic signed [DW-1:0]  t4_dz_q;

  logic                     t5_v_q;
  logic signed [ZW-1:0]     t5_x_q [3];
  logic signed [ZW-1:0]     t5_z_q [3];
  logic signed [YW-1:0]     t5_y_q [3];
  logic signed [DW-1:0]     t5_dx_q;
  logic signed [DW-1:0]     t5_dz_q;
  logic signed [YW+CW-1:0]  t5_py_q [3];

  // finished matrix, saturated to the coordinate range
  logic                 t6_v_q;
  logic signed [CW-1:0] t6_x_q [3];
  logic signed [CW-1:0] t6_y_q [3];
  logic signed [CW-1:0] t6_z_q [3];
  logic signed [CW-1:0] t6_c3_q [3];
  logic signed [63:0]   dy_sum;

  // column sequencer
  logic                 ser_v_q;
  logic [1:0]           col_q;
  logic signed [CW-1:0] ser_x_q [3];
  logic signed [CW-1:0] ser_y_q [3];
  logic signed [CW-1:0] ser_z_q [3];
  logic signed [CW-1:0] ser_c3_q [3];

  // ---------------------------------------------------------------- config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q[0] <= '0;
      up_q[1] <= ONE_FX;
      up_q[2] <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_UP_X: up_q[0] <= cfg_data_i;
        REG_UP_Y: up_q[1] <= cfg_data_i;
        REG_UP_Z: up_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------- handshake
  // the sequencer takes a new matrix when empty or on the last column leaving
  assign ser_take   = !ser_v_q || (col_q == LAST_COL && !out_stall_i);
  assign adv        = !t6_v_q || ser_take;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t0_v_q <= 1'b0;
      t1_v_q <= 1'b0;
      t2_v_q <= 1'b0;
      t3_v_q <= 1'b0;
      t4_v_q <= 1'b0;
      t5_v_q <= 1'b0;
      t6_v_q <= 1'b0;
    end else if (adv) begin
      t0_v_q <= in_valid_i;
      t1_v_q <= nz_v;
      t2_v_q <= t1_v_q;
      t3_v_q <= nx_v;
      t4_v_q <= t3_v_q;
      t5_v_q <= t4_v_q;
      t6_v_q <= t5_v_q;
    end
  end

  // ------------------------------------------------------------ input stage
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t0_eye_q[0] <= eye_x_i;
      t0_eye_q[1] <= eye_y_i;
      t0_eye_q[2] <= eye_z_i;
      t0_d_q[0]   <= (CW+1)'(target_x_i) - (CW+1)'(eye_x_i);
      t0_d_q[1]   <= (CW+1)'(target_y_i) - (CW+1)'(eye_y_i);
      t0_d_q[2]   <= (CW+1)'(target_z_i) - (CW+1)'(eye_z_i);
    end
  end

  // ----------------------------------------------------------- forward axis
  lav_norm #(
    .IW (CW + 1),
    .SW (ESW)
  ) u_norm_z (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .v_i    (t0_v_q),
    .a_i    (t0_d_q),
    .side_i ({t0_eye_q[0], t0_eye_q[1], t0_eye_q[2]}),
    .v_o    (nz_v),
    .r_o    (nz_r),
    .side_o (nz_side)
  );

  assign nz_eye[0] = nz_side[3*CW-1:2*CW];
  assign nz_eye[1] = nz_side[2*CW-1:CW];
  assign nz_eye[2] = nz_side[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t1_z_q   <= nz_r;
      t1_eye_q <= nz_eye;
      t1_p_q[0] <= up_q[1] * nz_r[2];
      t1_p_q[1] <= up_q[2] * nz_r[1];
      t1_p_q[2] <= up_q[2] * nz_r[0];
      t1_p_q[3] <= up_q[0] * nz_r[2];
      t1_p_q[4] <= up_q[0] * nz_r[1];
      t1_p_q[5] <= up_q[1] * nz_r[0];
    end
  end

  // up parallel to forward: the cross rounds to zero in every component
  always_comb begin
    degen = 1'b1;
    for (int i = 0; i < 3; i++) begin
      c_raw[i] = t1_p_q[2*i] - t1_p_q[2*i+1];
      if (c_raw[i] >= HALF_LSB || c_raw[i] <= -HALF_LSB) begin
        degen = 1'b0;
      end
    end
    zm1   = t1_z_q[1][ZW-1] ? ZW'(-t1_z_q[1]) : ZW'(t1_z_q[1]);
    zm2   = t1_z_q[2][ZW-1] ? ZW'(-t1_z_q[2]) : ZW'(t1_z_q[2]);
    use_y = zm1 < zm2;
    if (!degen) begin
      c_sel = c_raw;
    end else if (use_y) begin
      // hint becomes Y
      c_sel[0] = CPW'(t1_z_q[2]) <<< FB;
      c_sel[1] = '0;
      c_sel[2] = -(CPW'(t1_z_q[0]) <<< FB);
    end else begin
      // hint becomes Z
      c_sel[0] = -(CPW'(t1_z_q[1]) <<< FB);
      c_sel[1] = CPW'(t1_z_q[0]) <<< FB;
      c_sel[2] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t2_z_q   <= t1_z_q;
      t2_eye_q <= t1_eye_q;
      t2_c_q   <= c_sel;
    end
  end

  // -------------------------------------------------------------- right axis
  lav_norm #(
    .IW (CPW),
    .SW (XSW)
  ) u_norm_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .v_i    (t2_v_q),
    .a_i    (t2_c_q),
    .side_i ({t2_z_q[0], t2_z_q[1], t2_z_q[2], t2_eye_q[0], t2_eye_q[1], t2_eye_q[2]}),
    .v_o    (nx_v),
    .r_o    (nx_r),
    .side_o (nx_side)
  );

  assign nx_z[0]   = nx_side[XSW-1:XSW-ZW];
  assign nx_z[1]   = nx_side[XSW-ZW-1:XSW-2*ZW];
  assign nx_z[2]   = nx_side[XSW-2*ZW-1:ESW];
  assign nx_eye[0] = nx_side[3*CW-1:2*CW];
  assign nx_eye[1] = nx_side[2*CW-1:CW];
  assign nx_eye[2] = nx_side[CW-1:0];

  // ----------------------------------------------- reoriented up, dot products
  always_ff @(posedge clk_i) begin
    if (adv) begin
      t3_x_q   <= nx_r;
      t3_z_q   <= nx_z;
      t3_eye_q <= nx_eye;
      t3_pc_q[0] <= nx_z[1] * nx_r[2];
      t3_pc_q[1] <= nx_z[2] * nx_r[1];
      t3_pc_q[2] <= nx_z[2] * nx_r[0];
      t3_pc_q[3] <= nx_z[0] * nx_r[2];
      t3_pc_q[4] <= nx_z[0] * nx_r[1];
      t3_pc_q[5] <= nx_z[1] * nx_r[0];
      for (int i = 0; i < 3; i++) begin
        t3_px_q[i] <= nx_r[i] * nx_eye[i];
        t3_pz_q[i] <= nx_z[i] * nx_eye[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t4_x_q   <= t3_x_q;
      t4_z_q   <= t3_z_q;
      t4_eye_q <= t3_eye_q;
      for (int i = 0; i < 3; i++) begin
        t4_y_q[i] <= YW'(rnd_fb(64'(t3_pc_q[2*i]) - 64'(t3_pc_q[2*i+1])));
      end
      t4_dx_q <= DW'(64'(t3_px_q[0]) + 64'(t3_px_q[1]) + 64'(t3_px_q[2]));
      t4_dz_q <= DW'(64'(t3_pz_q[0]) + 64'(t3_pz_q[1]) + 64'(t3_pz_q[2]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      t5_x_q  <= t4_x_q;
      t5_y_q  <= t4_y_q;
      t5_z_q  <= t4_z_q;
      t5_dx_q <= t4_dx_q;
      t5_dz_q <= t4_dz_q;
      for (int i = 0; i < 3; i++) begin
        t5_py_q[i] <= t4_y_q[i] * t4_eye_q[i];
      end
    end
  end

  assign dy_sum = 64'(t5_py_q[0]) + 64'(t5_py_q[1]) + 64'(t5_py_q[2]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        t6_x_q[i] <= sat_cw(64'(t5_x_q[i]));
        t6_y_q[i] <= sat_cw(64'(t5_y_q[i]));
        t6_z_q[i] <= sat_cw(64'(t5_z_q[i]));
      end
      t6_c3_q[0] <= sat_cw(-rnd_fb(64'(t5_dx_q)));
      t6_c3_q[1] <= sat_cw(-rnd_fb(dy_sum));
      t6_c3_q[2] <= sat_cw(-rnd_fb(64'(t5_dz_q)));
    end
  end

  // -------------------------------------------------------- column sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q <= 1'b0;
      col_q   <= '0;
    end else if (ser_take) begin
      ser_v_q <= t6_v_q;
      col_q   <= '0;
    end else if (ser_v_q && !out_stall_i) begin
      col_q <= col_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_take) begin
      ser_x_q  <= t6_x_q;
      ser_y_q  <= t6_y_q;
      ser_z_q  <= t6_z_q;
      ser_c3_q <= t6_c3_q;
    end
  end

  always_comb begin
    case (col_q)
      2'd0: begin
        entry_row0_o = ser_x_q[0];
        entry_row1_o = ser_y_q[0];
        entry_row2_o = ser_z_q[0];
        entry_row3_o = '0;
      end
      2'd1: begin
        entry_row0_o = ser_x_q[1];
        entry_row1_o = ser_y_q[1];
        entry_row2_o = ser_z_q[1];
        entry_row3_o = '0;
      end
      2'd2: begin
        entry_row0_o = ser_x_q[2];
        entry_row1_o = ser_y_q[2];
        entry_row2_o = ser_z_q[2];
        entry_row3_o = '0;
      end
      default: begin
        // translation column
        entry_row0_o = ser_c3_q[0];
        entry_row1_o = ser_c3_q[1];
        entry_row2_o = ser_c3_q[2];
        entry_row3_o = ONE_FX;
      end
    endcase
  end

  assign out_valid_o    = ser_v_q;
  assign column_index_o = col_q;
  assign last_column_o  = col_q == LAST_COL;

endmodule

FILE: rtl/lav_norm.sv
// ----------------------------------------------------------------------------
// lav_norm
// Pipelined 3-vector normalizer: range shift, squares, root, three dividers.
// ----------------------------------------------------------------------------
module lav_norm #(
  parameter int IW = 33,
  parameter int SW = 96
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            v_i,
  input  logic signed [IW-1:0]            a_i [3],
  input  logic [SW-1:0]                   side_i,
  output logic                            v_o,
  output logic signed [lav_pkg::ZW-1:0]   r_o [3],
  output logic [SW-1:0]                   side_o
);
  import lav_pkg::*;

  localparam int PW = $clog2(IW);
  localparam int MS = 3 + SQ_STG;
  localparam int NS = MS + DIV_STG;

  logic [NS-1:0]   v_q;
  logic [NS-1:0]   zero_q;
  logic [2:0]      sgn_q [NS];
  logic [SW-1:0]   side_q [NS];
  logic [NB-1:0]   m_q [MS][3];
  logic [2*NB-1:0] sqr_q [3];
  logic [2*NB+1:0] sum_q;
  sq_st_t          sqs_q [SQ_STG];
  logic [LW-1:0]   len_q [DIV_STG];
  div_st_t         dv_q [DIV_STG][3];

  logic [IW-1:0]   mag [3];
  logic [IW-1:0]   orv;
  logic [PW-1:0]   pos;
  logic [NB-1:0]   nm [3];
  logic [2:0]      sg;
  sq_st_t          sq_d [SQ_STG];
  logic [LW-1:0]   len0;
  div_st_t         dv_d [DIV_STG][3];
  div_st_t         dv_in;

  // range shift so the largest magnitude has its top bit at NB-1
  always_comb begin
    orv = '0;
    for (int i = 0; i < 3; i++) begin
      sg[i]  = a_i[i][IW-1];
      mag[i] = a_i[i][IW-1] ? IW'(-a_i[i]) : IW'(a_i[i]);
      orv    = orv | mag[i];
    end
    pos = '0;
    for (int b = 0; b < IW; b++) begin
      if (orv[b]) begin
        pos = PW'(b);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (pos >= PW'(NB - 1)) begin
        nm[i] = NB'(mag[i] >> (pos - PW'(NB - 1)));
      end else begin
        nm[i] = NB'(mag[i] << (PW'(NB - 1) - pos));
      end
    end
  end

  assign len0 = sqs_q[SQ_STG-1].res[LW-1:0];

  always_comb begin
    for (int s = 0; s < SQ_STG; s++) begin
      if (s == 0) begin
        sq_d[s] = sqrt_steps('{n: 64'(sum_q), res: 64'(0)}, 0);
      end else begin
        sq_d[s] = sqrt_steps(sqs_q[s-1], s * SQ_STEPS);
      end
    end
    for (int s = 0; s < DIV_STG; s++) begin
      for (int i = 0; i < 3; i++) begin
        if (s == 0) begin
          dv_in.rem = RW'({m_q[MS-1][i], FB'(0)}) + RW'(len0 >> 1);
          dv_in.q   = '0;
          dv_d[s][i] = div_steps(dv_in, len0, 0);
        end else begin
          dv_in = dv_q[s-1][i];
          dv_d[s][i] = div_steps(dv_in, len_q[s-1], s * DIV_STEPS);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NS-2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zero_q    <= {zero_q[NS-2:0], orv == '0};
      sgn_q[0]  <= sg;
      side_q[0] <= side_i;
      for (int s = 1; s < NS; s++) begin
        sgn_q[s]  <= sgn_q[s-1];
        side_q[s] <= side_q[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        m_q[0][i] <= nm[i];
        sqr_q[i]  <= m_q[0][i] * m_q[0][i];
      end
      for (int s = 1; s < MS; s++) begin
        m_q[s] <= m_q[s-1];
      end
      sum_q <= (2*NB+2)'(sqr_q[0]) + (2*NB+2)'(sqr_q[1]) + (2*NB+2)'(sqr_q[2]);
      for (int s = 0; s < SQ_STG; s++) begin
        sqs_q[s] <= sq_d[s];
      end
      for (int s = 0; s < DIV_STG; s++) begin
        len_q[s] <= (s == 0) ? len0 : len_q[s-1];
        dv_q[s]  <= dv_d[s];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (zero_q[NS-1]) begin
        r_o[i] = '0;
      end else if (sgn_q[NS-1][i]) begin
        r_o[i] = -ZW'(dv_q[DIV_STG-1][i].q);
      end else begin
        r_o[i] = ZW'(dv_q[DIV_STG-1][i].q);
      end
    end
  end

  assign v_o    = v_q[NS-1];
  assign side_o = side_q[NS-1];

endmodule
